// ----- sv/lcma_pkg.sv -----
package lcma_pkg;

  // Configuration register indexes.
  localparam logic [1:0] REG_WINDOW_LENGTH = 2'd0;
  localparam logic [1:0] REG_ZERO_OFFSET   = 2'd1;
  localparam logic [1:0] REG_SCALE_Q32     = 2'd2;

  localparam int unsigned WINDOW_RESET = 16;
  localparam logic [31:0] SCALE_RESET  = 32'd2899102;

  localparam int unsigned SAMPLE_W = 24;
  localparam int unsigned SUM_W    = 32;
  localparam int unsigned COUNT_W  = 8;
  localparam int unsigned FORCE_W  = 41;
  localparam int unsigned PROD_W   = 58;
  localparam int unsigned OUT_W    = 80;

  // Request from the sequencer to the divider.
  typedef struct packed {
    logic                    start;
    logic signed [SUM_W-1:0] dividend;
    logic [COUNT_W-1:0]      divisor;
  } div_req_t;

endpackage

// ----- sv/load_cell_moving_average.sv -----
// An accepted input item passes through the READ, START, DIV, MUL and OUT states before m_tvalid rises with its result.
// A new item is taken only in the idle state, after the last one has left OUT; the bit-serial divider sets the rate.
// The next item is accepted while a finished result still waits on m_tready.
// Reset (synchronous, rst high) restores the control and configuration registers to their defaults and
// empties the window; the sample memory is not cleared and needs no sweep.
module load_cell_moving_average
  import lcma_pkg::*;
#(
  parameter int unsigned MAX_WINDOW = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [23:0]       s_tdata,   // raw_word [23:0]
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [OUT_W-1:0]  m_tdata,   // mean_value [23:0], filled_count [31:24],
                                       // force_q16 [72:32], zero [79:73]
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [31:0]       cfg_data
);

  localparam int unsigned AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam logic [COUNT_W:0] MAX_WIN_V = (COUNT_W+1)'(MAX_WINDOW);
  localparam logic [COUNT_W-1:0] WLEN_RST =
    (MAX_WINDOW < WINDOW_RESET) ? COUNT_W'(MAX_WINDOW) : COUNT_W'(WINDOW_RESET);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_READ  = 3'd1;
  localparam logic [2:0] S_START = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_MUL   = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0] state;

  logic [COUNT_W-1:0]        window_length;
  logic signed [SAMPLE_W-1:0] zero_offset;
  logic [31:0]               scale_q32;

  logic signed [SUM_W-1:0] running_sum;
  logic [COUNT_W-1:0]      fill_level;
  logic [COUNT_W-1:0]      oldest_slot;

  logic [SAMPLE_W-1:0]        sample;
  logic signed [SAMPLE_W-1:0] mean;
  logic [PROD_W-1:0]          prod;

  logic [SAMPLE_W-1:0] old_sample;
  logic                full;
  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  logic signed [SUM_W-1:0] sum_next;
  logic [COUNT_W:0]    slot_inc;

  logic [COUNT_W-1:0] wlen_in;
  logic [COUNT_W-1:0] wlen_sat;

  div_req_t                div_req;
  logic                    div_done;
  logic signed [SUM_W-1:0] div_q;

  logic signed [SAMPLE_W:0] diff;
  logic                     out_load;

  assign s_tready = (state == S_IDLE);

  lcma_store #(
    .DEPTH (MAX_WINDOW),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (sample),
    .raddr (oldest_slot[AW-1:0]),
    .rdata (old_sample)
  );

  lcma_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    full      = (fill_level >= window_length);
    mem_we    = (state == S_READ);
    mem_waddr = full ? oldest_slot[AW-1:0] : fill_level[AW-1:0];
    sum_next  = running_sum + SUM_W'(signed'(sample))
              - (full ? SUM_W'(signed'(old_sample)) : SUM_W'(0));
    slot_inc  = {1'b0, oldest_slot} + (COUNT_W+1)'(1);

    wlen_in  = cfg_data[COUNT_W-1:0];
    wlen_sat = ({1'b0, wlen_in} > MAX_WIN_V) ? MAX_WIN_V[COUNT_W-1:0] : wlen_in;

    div_req.start    = (state == S_START);
    div_req.dividend = running_sum;
    div_req.divisor  = fill_level;

    diff     = {mean[SAMPLE_W-1], mean} - {zero_offset[SAMPLE_W-1], zero_offset};
    out_load = (state == S_OUT) && (!m_tvalid || m_tready);
  end

  // Control and window state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      window_length <= WLEN_RST;
      zero_offset   <= '0;
      scale_q32     <= SCALE_RESET;
      running_sum   <= '0;
      fill_level    <= '0;
      oldest_slot   <= '0;
      m_tvalid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_WINDOW_LENGTH: begin
            // A zero length is dropped without touching the window.
            if (wlen_in != '0) begin
              window_length <= wlen_sat;
              running_sum   <= '0;
              fill_level    <= '0;
              oldest_slot   <= '0;
            end
          end
          REG_ZERO_OFFSET: zero_offset <= cfg_data[SAMPLE_W-1:0];
          REG_SCALE_Q32:   scale_q32   <= cfg_data;
          default: ;
        endcase
      end

      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            state <= S_READ;
          end
        end
        S_READ: begin
          running_sum <= sum_next;
          if (full) begin
            oldest_slot <= (slot_inc >= {1'b0, window_length}) ? '0 : slot_inc[COUNT_W-1:0];
          end else begin
            fill_level <= fill_level + COUNT_W'(1);
          end
          state <= S_START;
        end
        S_START: state <= S_DIV;
        S_DIV: begin
          if (div_done) begin
            state <= S_MUL;
          end
        end
        S_MUL: state <= S_OUT;
        S_OUT: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      sample <= s_tdata;
    end
    if (state == S_DIV && div_done) begin
      mean <= div_q[SAMPLE_W-1:0];
    end
    if (state == S_MUL) begin
      prod <= {{(PROD_W-SAMPLE_W-1){diff[SAMPLE_W]}}, diff} * {{(PROD_W-32){1'b0}}, scale_q32};
    end
    if (out_load) begin
      m_tdata <= {{(OUT_W-FORCE_W-SUM_W){1'b0}}, prod[FORCE_W+15:16], fill_level, mean};
    end
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_level <= window_length) else $error("fill level beyond window length");

  a_slot_bound: assert property (@(posedge clk) disable iff (rst)
    oldest_slot < window_length) else $error("oldest slot outside window");

  a_slot_while_filling: assert property (@(posedge clk) disable iff (rst)
    (fill_level != window_length) |-> (oldest_slot == '0))
    else $error("ring advanced before window filled");

  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIV)) else $error("divider finished outside divide state");
`endif

endmodule

// ----- sv/lcma_store.sv -----
module lcma_store
  import lcma_pkg::*;
#(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8
) (
  input  logic                clk,
  input  logic                we,
  input  logic [AW-1:0]       waddr,
  input  logic [SAMPLE_W-1:0] wdata,
  input  logic [AW-1:0]       raddr,
  output logic [SAMPLE_W-1:0] rdata
);

  logic [SAMPLE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/lcma_div.sv -----
module lcma_div
  import lcma_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  div_req_t                req,
  output logic                    done,
  output logic signed [SUM_W-1:0] quotient
);

  // Restoring division of the magnitude, one quotient bit per cycle.
  logic [SUM_W-1:0]   dq;
  logic [COUNT_W-1:0] rem;
  logic [COUNT_W-1:0] divisor;
  logic [4:0]         cnt;
  logic               busy;
  logic               neg;

  logic [COUNT_W:0]   trial;
  logic               ge;
  logic [COUNT_W-1:0] rem_next;
  logic [SUM_W-1:0]   dq_next;

  always_comb begin
    trial    = {rem, dq[SUM_W-1]};
    ge       = (trial >= {1'b0, divisor});
    rem_next = ge ? COUNT_W'(trial - {1'b0, divisor}) : trial[COUNT_W-1:0];
    dq_next  = {dq[SUM_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      neg     <= req.dividend[SUM_W-1];
      dq      <= req.dividend[SUM_W-1] ? SUM_W'(-req.dividend) : req.dividend;
      rem     <= '0;
      divisor <= req.divisor;
    end else if (busy) begin
      dq  <= dq_next;
      rem <= rem_next;
    end
  end

  assign quotient = neg ? -signed'(dq) : signed'(dq);

endmodule

// ----- dv/tb_load_cell_moving_average.sv -----
`timescale 1ns / 1ps

module tb_load_cell_moving_average;
  import lcma_pkg::*;

  localparam int unsigned MAX_WIN = 256;
  localparam logic [1:0] REG_SPARE = 2'd3;
  localparam int unsigned RANDOM_ITEMS = 1900;

  // One result item as it sits in m_tdata, highest field first.
  typedef struct packed {
    logic [6:0]         pad;
    logic signed [40:0] force_q16;
    logic [7:0]         count;
    logic signed [23:0] mean;
  } reading_t;

  class force_reading_board;
    int unsigned        win_len;
    logic signed [23:0] offset;
    logic [31:0]        scale;
    logic signed [23:0] samples [MAX_WIN];
    longint             sum;
    int unsigned        fill;
    int unsigned        oldest;
    reading_t           expected_readings [$];
    int unsigned        mismatches;
    int unsigned        checked;

    function void clear_window();
      sum = 0;
      fill = 0;
      oldest = 0;
    endfunction

    function void reset_state();
      win_len = WINDOW_RESET;
      offset = '0;
      scale = SCALE_RESET;
      clear_window();
    endfunction

    function void write_register(logic [1:0] idx, logic [31:0] data);
      case (idx)
        REG_WINDOW_LENGTH: begin
          // A zero length is dropped without touching the window.
          if (data[7:0] != 8'd0) begin
            win_len = 32'(data[7:0]);
            if (win_len > MAX_WIN) win_len = MAX_WIN;
            clear_window();
          end
        end
        REG_ZERO_OFFSET: offset = data[23:0];
        REG_SCALE_Q32:   scale = data;
        default: ;
      endcase
    endfunction

    function void note_sample(logic [23:0] raw);
      logic signed [23:0] s;
      longint             mean_l;
      longint             prod;
      reading_t           r;
      s = raw;
      if (fill < win_len) begin
        samples[fill] = s;
        sum += s;
        fill++;
      end else begin
        sum = sum - samples[oldest] + s;
        samples[oldest] = s;
        oldest++;
        if (oldest >= win_len) oldest = 0;
      end
      mean_l = sum / longint'(fill);
      prod = (mean_l - longint'(offset)) * longint'(scale);
      prod = prod >>> 16;
      r.pad = '0;
      r.mean = mean_l[23:0];
      r.count = fill[7:0];
      r.force_q16 = prod[40:0];
      expected_readings.push_back(r);
    endfunction

    function void check_reading(logic [OUT_W-1:0] data);
      reading_t got;
      reading_t want;
      got = data;
      checked++;
      if (expected_readings.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected reading mean=%0d count=%0d force=%0d", $realtime,
                   got.mean, got.count, got.force_q16);
        return;
      end
      want = expected_readings.pop_front();
      if (got.mean !== want.mean || got.count !== want.count ||
          got.force_q16 !== want.force_q16 || got.pad !== want.pad) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: reading mismatch: expected mean=%0d count=%0d force=%0d pad=%0h,",
                   $realtime, want.mean, want.count, want.force_q16, want.pad);
          $display("    got mean=%0d count=%0d force=%0d pad=%0h",
                   got.mean, got.count, got.force_q16, got.pad);
        end
      end
    endfunction

    function int unsigned pending_count();
      return expected_readings.size();
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [23:0]       s_tdata = '0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [OUT_W-1:0]  m_tdata;
  logic              cfg_we = 1'b0;
  logic [1:0]        cfg_index = '0;
  logic [31:0]       cfg_data = '0;

  force_reading_board board;
  int unsigned sent;
  int unsigned cfg_writes;
  int unsigned burst_left;
  int unsigned narrowest = MAX_WIN;
  int unsigned widest;
  int unsigned stall_mode;
  int unsigned stall_left;

  load_cell_moving_average #(.MAX_WINDOW(MAX_WIN)) u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  initial begin
    #15_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Results are checked before the same edge's input is noted, so a stray
  // result never consumes the expectation of the item accepted alongside it.
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) board.check_reading(m_tdata);
      if (s_tvalid && s_tready) board.note_sample(s_tdata);
    end
  end

  // The receiver switches between always ready, coin flips, rare ready and long stalls.
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(20, 300);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= 1'($urandom_range(0, 1));
      2: m_tready <= ($urandom_range(0, 7) == 0);
      default: m_tready <= ((stall_left % 64) < 8);
    endcase
  end

  task automatic send_sample(input logic [23:0] raw);
    int unsigned gap;
    s_tvalid <= 1'b1;
    s_tdata <= raw;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent++;
    if (burst_left == 0) begin
      burst_left = $urandom_range(0, 12);
      case ($urandom_range(0, 4))
        0, 1: gap = 0;
        2, 3: gap = $urandom_range(1, 20);
        default: gap = $urandom_range(20, 80);
      endcase
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  task automatic wait_for_readings();
    s_tvalid <= 1'b0;
    repeat (2) @(posedge clk);
    while (board.pending_count() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    board.write_register(idx, data);
    cfg_writes++;
    if (idx == REG_WINDOW_LENGTH && data[7:0] != 8'd0) begin
      if (data[7:0] < narrowest) narrowest = 32'(data[7:0]);
      if (data[7:0] > widest) widest = 32'(data[7:0]);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [23:0] pick_raw(logic [23:0] level);
    case ($urandom_range(0, 9))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      2, 3: return 24'($urandom());
      default: return level + 24'($urandom_range(0, 511)) - 24'd256;
    endcase
  endfunction

  function automatic logic [7:0] pick_window();
    case ($urandom_range(0, 7))
      0: return 8'd1;
      1: return 8'd255;
      2: return 8'($urandom_range(1, 255));
      3: return 8'd2;
      default: return 8'($urandom_range(2, 24));
    endcase
  endfunction

  function automatic logic [23:0] pick_offset();
    case ($urandom_range(0, 5))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      2: return 24'h000000;
      default: return 24'($urandom());
    endcase
  endfunction

  function automatic logic [31:0] pick_scale();
    case ($urandom_range(0, 5))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return SCALE_RESET;
      default: return $urandom();
    endcase
  endfunction

  logic [23:0] corner_words [12] = '{
    24'h7FFFFF, 24'h7FFFFF, 24'h800000, 24'h800000, 24'hFFFFFF, 24'h000000,
    24'h000001, 24'h800001, 24'h123456, 24'hFEDCBA, 24'h555555, 24'hAAAAAA
  };

  initial begin
    int unsigned random_sent;
    int unsigned phase;
    int unsigned run_len;
    logic [23:0] level;

    board = new();
    board.reset_state();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings, window of 16 partly filled with the twelve corner words.
    foreach (corner_words[i]) send_sample(corner_words[i]);
    wait_for_readings();

    // A zero window length and a write to the spare index must leave all state alone.
    write_reg(REG_WINDOW_LENGTH, {24'($urandom_range(0, 32'hFF_FFFF)), 8'd0});
    write_reg(REG_SPARE, $urandom());
    send_sample(24'h7FFFFF);
    send_sample(24'h800000);
    send_sample(24'h000002);
    wait_for_readings();

    // Single-sample window against opposite offsets and the full scale gives
    // the largest force magnitudes of either sign.
    write_reg(REG_WINDOW_LENGTH, 32'h0000_0001);
    write_reg(REG_SCALE_Q32, 32'hFFFF_FFFF);
    write_reg(REG_ZERO_OFFSET, 32'hFF7F_FFFF);
    send_sample(24'h800000);
    send_sample(24'h7FFFFF);
    wait_for_readings();
    write_reg(REG_ZERO_OFFSET, 32'h0080_0000);
    send_sample(24'h7FFFFF);
    send_sample(24'h800000);

    phase = 0;
    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      wait_for_readings();
      if (phase == 0)
        write_reg(REG_WINDOW_LENGTH, {24'($urandom_range(0, 32'hFF_FFFF)), 8'd255});
      else if ($urandom_range(0, 3) != 0)
        write_reg(REG_WINDOW_LENGTH, {24'($urandom_range(0, 32'hFF_FFFF)), pick_window()});
      if ($urandom_range(0, 1) == 0)
        write_reg(REG_ZERO_OFFSET, {8'($urandom()), pick_offset()});
      if ($urandom_range(0, 1) == 0) write_reg(REG_SCALE_Q32, pick_scale());
      if ($urandom_range(0, 5) == 0) write_reg(REG_WINDOW_LENGTH, {24'($urandom()), 8'd0});
      if ($urandom_range(0, 5) == 0) write_reg(REG_SPARE, $urandom());
      level = 24'($urandom());
      run_len = board.win_len + $urandom_range(1, 2 * board.win_len + 8);
      if (run_len > RANDOM_ITEMS - random_sent) run_len = RANDOM_ITEMS - random_sent;
      repeat (run_len) begin
        send_sample(pick_raw(level));
        random_sent++;
        if ($urandom_range(0, 79) == 0) wait_for_readings();
      end
      phase++;
    end

    wait_for_readings();
    repeat (60) @(posedge clk);
    $display("Sent %0d samples over %0d setting phases, %0d register writes;", sent, phase,
             cfg_writes);
    $display("checked %0d readings with windows from %0d to %0d samples.", board.checked,
             narrowest, widest);
    if (board.mismatches == 0 && board.pending_count() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches, %0d readings missing", board.mismatches,
               board.pending_count());
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
